>>> src/bhct_pkg.sv
// shared types and constants of the backend health and connection table
`timescale 1ns / 1ps
`default_nettype none

package bhct_pkg;

	// event codes, anything above query acts as a query
	localparam logic [2:0] OP_OPEN       = 3'd0;
	localparam logic [2:0] OP_CLOSE      = 3'd1;
	localparam logic [2:0] OP_PROBE_OK   = 3'd2;
	localparam logic [2:0] OP_PROBE_FAIL = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_BACKEND_COUNT = 2'd0;
	localparam logic [1:0] CFG_WEIGHT_TABLE  = 2'd1;
	localparam logic [1:0] CFG_LIMIT_TABLE   = 2'd2;

	localparam logic [15:0] CONN_MAX      = 16'hffff;
	localparam logic [3:0]  FAIL_MAX      = 4'd15;
	localparam logic [3:0]  DEFAULT_LIMIT = 4'd3;
	localparam logic [7:0]  DEFAULT_WEIGHT = 8'd1;

	localparam int SUM_W = 11;

	// one event as it leaves the input register
	typedef struct packed {
		logic       valid;
		logic [2:0] op;
		logic [2:0] idx;
	} bhct_event_t;

	// entry state reported for one event
	typedef struct packed {
		logic [15:0] conn;
		logic [3:0]  fail;
		logic        healthy;
		logic        changed;
		logic        index_error;
	} bhct_entry_t;

endpackage

`default_nettype wire

>>> src/backend_health_connection_table.sv
// top level of the backend health and connection table
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   event word, tdata
// m_axis    out  m_axis_tvalid/m_axis_tready   result word, tdata
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// one word per cycle sustained while results are taken: the input register feeds
// a single pass of entry update and weight sum into the result register
// reset: all entries healthy with zero counts, all config registers zero
// a stalled result holds the input register, input ready drops only then
// cfg_ready is always high; config is to be written by the user only while the
// block is idle, the block itself does not enforce it
`timescale 1ns / 1ps
`default_nettype none

module backend_health_connection_table #(
	parameter int NUM_BACKENDS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// event stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // op[2:0], backend_index[5:3], zero[7:6]
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // active_connections[15:0], failure_count[19:16],
	                                    // healthy[20], health_changed[21],
	                                    // total_healthy_weight[32:22], index_error[33],
	                                    // zero[39:34]
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [63:0] cfg_data
);

	// config registers
	logic [3:0]  backend_count_q;
	logic [63:0] weight_table_q;
	logic [31:0] limit_table_q;
	logic [3:0]  live_count;

	// input register
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [2:0]  idx_s1;

	// result register
	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic                        s_accept;
	logic                        advance;
	bhct_pkg::bhct_event_t       ev;
	bhct_pkg::bhct_entry_t       entry;
	logic [NUM_BACKENDS-1:0]     flags_next;
	logic [bhct_pkg::SUM_W-1:0]  total;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backend_count_q <= '0;
			weight_table_q  <= '0;
			limit_table_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bhct_pkg::CFG_BACKEND_COUNT: backend_count_q <= cfg_data[3:0];
				bhct_pkg::CFG_WEIGHT_TABLE:  weight_table_q  <= cfg_data;
				bhct_pkg::CFG_LIMIT_TABLE:   limit_table_q   <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// counts above the table size clamp to the table size
	assign live_count = (backend_count_q > 4'(NUM_BACKENDS)) ? 4'(NUM_BACKENDS)
	                                                          : backend_count_q;

	// the update happens when the result register can take the word
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1  <= s_axis_tdata[2:0];
			idx_s1 <= s_axis_tdata[5:3];
		end
	end

	assign ev.valid = valid_s1;
	assign ev.op    = op_s1;
	assign ev.idx   = idx_s1;

	bhct_table #(
		.NUM_BACKENDS(NUM_BACKENDS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev),
		.upd_en     (advance),
		.live_count (live_count),
		.limit_table(limit_table_q),
		.flags_next (flags_next),
		.entry      (entry)
	);

	// total reflects the flags after this event
	bhct_weight_sum #(
		.NUM_BACKENDS(NUM_BACKENDS)
	) u_weight_sum (
		.weight_table(weight_table_q),
		.flags       (flags_next),
		.live_count  (live_count),
		.total       (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'd0, entry.index_error, total, entry.changed,
			               entry.healthy, entry.fail, entry.conn};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// a bad index reports a cleared entry
	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[21:0] == 22'd0)
		else $error("index error with nonzero entry fields");

	// an entry that turned healthy has no failures left
	a_recover_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[21] && m_axis_tdata[20] |->
			m_axis_tdata[19:16] == 4'd0)
		else $error("recovered entry with failures left");

	// input stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without a stalled result");

	// an update always lands in the result register
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("update without a result word");
`endif

endmodule

`default_nettype wire

>>> src/bhct_table.sv
// entry state registers and per-entry event update
`timescale 1ns / 1ps
`default_nettype none

module bhct_table #(
	parameter int NUM_BACKENDS = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire bhct_pkg::bhct_event_t  ev,
	input  wire                         upd_en,
	input  wire  [3:0]                  live_count,
	input  wire  [31:0]                 limit_table,
	output logic [NUM_BACKENDS-1:0]     flags_next,
	output bhct_pkg::bhct_entry_t       entry
);

	logic [15:0] conn_q [NUM_BACKENDS];
	logic [3:0]  fail_q [NUM_BACKENDS];
	logic [NUM_BACKENDS-1:0] flag_q;

	logic [15:0] conn_n [NUM_BACKENDS];
	logic [3:0]  fail_n [NUM_BACKENDS];
	logic [NUM_BACKENDS-1:0] chg_n;
	logic        hit;

	assign hit = ({1'b0, ev.idx} < live_count);

	always_comb begin
		logic [3:0] lim;
		logic [3:0] f1;
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			conn_n[i]     = conn_q[i];
			fail_n[i]     = fail_q[i];
			flags_next[i] = flag_q[i];
			chg_n[i]      = 1'b0;
			lim = limit_table[4*i +: 4];
			if (lim == 4'd0) begin
				lim = bhct_pkg::DEFAULT_LIMIT;
			end
			f1 = (fail_q[i] < bhct_pkg::FAIL_MAX) ? fail_q[i] + 4'd1 : fail_q[i];
			if (ev.valid && hit && (ev.idx == 3'(i))) begin
				case (ev.op)
					bhct_pkg::OP_OPEN: begin
						if (conn_q[i] < bhct_pkg::CONN_MAX) begin
							conn_n[i] = conn_q[i] + 16'd1;
						end
					end
					bhct_pkg::OP_CLOSE: begin
						if (conn_q[i] != 16'd0) begin
							conn_n[i] = conn_q[i] - 16'd1;
						end
					end
					bhct_pkg::OP_PROBE_OK: begin
						fail_n[i]     = 4'd0;
						flags_next[i] = 1'b1;
						chg_n[i]      = !flag_q[i];
					end
					bhct_pkg::OP_PROBE_FAIL: begin
						fail_n[i] = f1;
						if ((f1 >= lim) && flag_q[i]) begin
							flags_next[i] = 1'b0;
							chg_n[i]      = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// report the selected entry after the event, zeros on a bad index
	always_comb begin
		entry = '0;
		entry.index_error = !hit;
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			if (hit && (ev.idx == 3'(i))) begin
				entry.conn    = conn_n[i];
				entry.fail    = fail_n[i];
				entry.healthy = flags_next[i];
				entry.changed = chg_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BACKENDS; i++) begin
				conn_q[i] <= '0;
				fail_q[i] <= '0;
			end
			flag_q <= '1;
		end else if (upd_en) begin
			for (int i = 0; i < NUM_BACKENDS; i++) begin
				conn_q[i] <= conn_n[i];
				fail_q[i] <= fail_n[i];
			end
			flag_q <= flags_next;
		end
	end

endmodule

`default_nettype wire

>>> src/bhct_weight_sum.sv
// sum of effective weights over healthy live entries
`timescale 1ns / 1ps
`default_nettype none

module bhct_weight_sum #(
	parameter int NUM_BACKENDS = 8
) (
	input  wire  [63:0]                    weight_table,
	input  wire  [NUM_BACKENDS-1:0]        flags,
	input  wire  [3:0]                     live_count,
	output logic [bhct_pkg::SUM_W-1:0]     total
);

	always_comb begin
		logic [7:0] w;
		total = '0;
		for (int i = 0; i < NUM_BACKENDS; i++) begin
			w = weight_table[8*i +: 8];
			if (w == 8'd0) begin
				w = bhct_pkg::DEFAULT_WEIGHT;
			end
			if (flags[i] && (4'(i) < live_count)) begin
				total = total + bhct_pkg::SUM_W'(w);
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_backend_health_connection_table.sv
// self-checking testbench of the backend health and connection table
`timescale 1ns / 1ps

module tb_backend_health_connection_table;

	localparam int HOLD_CYCLES = 4;      // two-stage pipe plus margin
	localparam int STALL_LIMIT = 2000;   // cycles with no word moving anywhere
	localparam int DRAIN_LIMIT = 5000;
	localparam int ROUND_EVENTS = 160;

	// result word as it leaves m_axis_tdata, lowest field last
	typedef struct packed {
		logic [5:0]  pad;
		logic        index_error;
		logic [10:0] weight_sum;
		logic        changed;
		logic        healthy;
		logic [3:0]  fails;
		logic [15:0] conns;
	} table_result_t;

	typedef enum logic [1:0] {ROW_EVENT, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [2:0]    op;
		logic [2:0]    idx;
		int            reps;
		logic [1:0]    reg_sel;
		logic [63:0]   value;
		bit            typed;
		table_result_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	// shadow of the block: per-entry state and register copies
	logic [15:0] conn_cnt [8];
	logic [3:0]  fail_cnt [8];
	logic        up_flag  [8];
	logic [3:0]  live_cfg;
	logic [63:0] weight_cfg;
	logic [31:0] limit_cfg;

	table_result_t expected_q [$];
	plan_row_t     directed_plan [$];

	int src_stall_pct;
	int sink_stall_pct;
	int failures;
	int results_checked;
	int events_sent;
	int cfg_writes;
	int health_flips;
	int index_errors;
	int quiet_cycles;

	backend_health_connection_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// entries at or above the backend count are out of play, counts above 8 clamp
	function automatic int live_entries();
		return (live_cfg > 4'd8) ? 8 : int'(live_cfg);
	endfunction

	// sum of effective weights of the healthy entries in play, zero weight reads as 1
	function automatic logic [10:0] healthy_weight();
		int i;
		logic [7:0] w;
		logic [10:0] total;
		total = '0;
		for (i = 0; i < live_entries(); i++) begin
			if (up_flag[i]) begin
				w = weight_cfg[8*i +: 8];
				total = total + ((w == 8'd0) ? 11'd1 : 11'(w));
			end
		end
		return total;
	endfunction

	// applies one event to the shadow table and returns the word the block should send
	function automatic table_result_t apply_event(logic [2:0] op, logic [2:0] idx);
		table_result_t r;
		logic [3:0] lim;
		r = '0;
		if (int'(idx) >= live_entries()) begin
			// bad index: no state moves, only the error flag and the weight sum are reported
			r.index_error = 1'b1;
			r.weight_sum = healthy_weight();
			index_errors++;
			return r;
		end
		case (op)
			bhct_pkg::OP_OPEN: begin
				if (conn_cnt[idx] != bhct_pkg::CONN_MAX)
					conn_cnt[idx] = conn_cnt[idx] + 16'd1;
			end
			bhct_pkg::OP_CLOSE: begin
				if (conn_cnt[idx] != 16'd0)
					conn_cnt[idx] = conn_cnt[idx] - 16'd1;
			end
			bhct_pkg::OP_PROBE_OK: begin
				fail_cnt[idx] = 4'd0;
				if (!up_flag[idx]) begin
					up_flag[idx] = 1'b1;
					r.changed = 1'b1;
				end
			end
			bhct_pkg::OP_PROBE_FAIL: begin
				// failures stick at 15, the limit still trips at 15
				if (fail_cnt[idx] != bhct_pkg::FAIL_MAX)
					fail_cnt[idx] = fail_cnt[idx] + 4'd1;
				lim = limit_cfg[4*idx +: 4];
				if (lim == 4'd0)
					lim = bhct_pkg::DEFAULT_LIMIT;
				if (fail_cnt[idx] >= lim && up_flag[idx]) begin
					up_flag[idx] = 1'b0;
					r.changed = 1'b1;
				end
			end
			default: ;   // query and the unused codes leave the entry alone
		endcase
		r.conns = conn_cnt[idx];
		r.fails = fail_cnt[idx];
		r.healthy = up_flag[idx];
		r.weight_sum = healthy_weight();
		if (r.changed)
			health_flips++;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			failures++;
			if (failures <= 10)
				$display("mismatch in result %0d, %s: expected %0d, got %0d",
					results_checked, name, want, got);
		end
	endfunction

	// directed plan builders
	function automatic void plan_event(logic [2:0] op, logic [2:0] idx, int reps);
		plan_row_t row;
		row = '{kind: ROW_EVENT, op: op, idx: idx, reps: reps,
			reg_sel: bhct_pkg::CFG_BACKEND_COUNT, value: '0, typed: 1'b0, want: '0};
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_typed(logic [2:0] op, logic [2:0] idx, logic [15:0] conns,
			logic [3:0] fails, logic healthy, logic changed, logic [10:0] sum, logic err);
		plan_row_t row;
		row = '{kind: ROW_EVENT, op: op, idx: idx, reps: 1,
			reg_sel: bhct_pkg::CFG_BACKEND_COUNT, value: '0, typed: 1'b1, want: '0};
		row.want.conns = conns;
		row.want.fails = fails;
		row.want.healthy = healthy;
		row.want.changed = changed;
		row.want.weight_sum = sum;
		row.want.index_error = err;
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_cfg(logic [1:0] reg_sel, logic [63:0] value);
		plan_row_t row;
		row = '{kind: ROW_CONFIG, op: bhct_pkg::OP_QUERY, idx: '0, reps: 0, reg_sel: reg_sel,
			value: value, typed: 1'b0, want: '0};
		directed_plan.push_back(row);
	endfunction

	// drives one event word from a falling edge, returns at the falling edge after acceptance
	task automatic send_event(logic [2:0] op, logic [2:0] idx, bit typed, table_result_t typed_want);
		table_result_t predicted;
		while ($urandom_range(99) < src_stall_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, idx, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = apply_event(op, idx);
		expected_q.push_back(typed ? typed_want : predicted);
		events_sent++;
		@(negedge clk);
	endtask

	// stops sending and waits for the pipe to empty, registers are only written after this
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (HOLD_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] reg_sel, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_sel;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (reg_sel)
			bhct_pkg::CFG_BACKEND_COUNT: live_cfg = value[3:0];
			bhct_pkg::CFG_WEIGHT_TABLE:  weight_cfg = value;
			bhct_pkg::CFG_LIMIT_TABLE:   limit_cfg = value[31:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// receiver side: random back pressure, rate set per phase
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// result checker: every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_check
		table_result_t got;
		table_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = table_result_t'(m_axis_tdata);
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result word %h arrived with nothing outstanding", m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				check_field("active_connections", want.conns, got.conns);
				check_field("failure_count", want.fails, got.fails);
				check_field("healthy", want.healthy, got.healthy);
				check_field("health_changed", want.changed, got.changed);
				check_field("total_healthy_weight", want.weight_sum, got.weight_sum);
				check_field("index_error", want.index_error, got.index_error);
				check_field("padding", want.pad, got.pad);
			end
			results_checked++;
		end
	end

	// watchdog: a run where no word moves for too long is hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d results outstanding",
				STALL_LIMIT, expected_q.size());
			$display("backend_health_connection_table regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int k;
		int rep;
		int mode;
		int round;
		int n;
		int pick;
		int live;
		logic [2:0] op;
		logic [2:0] idx;
		logic [3:0] count_val;
		logic [63:0] weight_val;
		logic [31:0] limit_val;
		plan_row_t row;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = bhct_pkg::CFG_BACKEND_COUNT;
		cfg_data = '0;
		failures = 0;
		results_checked = 0;
		events_sent = 0;
		cfg_writes = 0;
		health_flips = 0;
		index_errors = 0;
		src_stall_pct = 21;
		sink_stall_pct = 50;
		live_cfg = '0;
		weight_cfg = '0;
		limit_cfg = '0;
		for (k = 0; k < 8; k++) begin
			conn_cnt[k] = '0;
			fail_cnt[k] = '0;
			up_flag[k] = 1'b1;
		end

		// after reset nothing is in play: every event is an index error with zero weight
		plan_typed(bhct_pkg::OP_OPEN, 3'd0, 16'd0, 4'd0, 1'b0, 1'b0, 11'd0, 1'b1);
		plan_typed(3'd7, 3'd7, 16'd0, 4'd0, 1'b0, 1'b0, 11'd0, 1'b1);
		// eight entries, default weight 1 and default limit 3
		plan_cfg(bhct_pkg::CFG_BACKEND_COUNT, 64'd8);
		plan_typed(bhct_pkg::OP_QUERY, 3'd0, 16'd0, 4'd0, 1'b1, 1'b0, 11'd8, 1'b0);
		plan_event(bhct_pkg::OP_PROBE_FAIL, 3'd2, 2);
		// third failure hits the default limit
		plan_typed(bhct_pkg::OP_PROBE_FAIL, 3'd2, 16'd0, 4'd3, 1'b0, 1'b1, 11'd7, 1'b0);
		plan_typed(bhct_pkg::OP_PROBE_FAIL, 3'd2, 16'd0, 4'd4, 1'b0, 1'b0, 11'd7, 1'b0);
		// one good probe clears the run and brings the entry back
		plan_typed(bhct_pkg::OP_PROBE_OK, 3'd2, 16'd0, 4'd0, 1'b1, 1'b1, 11'd8, 1'b0);
		// close on an idle entry stays at zero
		plan_typed(bhct_pkg::OP_CLOSE, 3'd1, 16'd0, 4'd0, 1'b1, 1'b0, 11'd8, 1'b0);
		// a few opens on entry 0 count up one by one
		plan_event(bhct_pkg::OP_OPEN, 3'd0, 3);
		plan_typed(bhct_pkg::OP_OPEN, 3'd0, 16'd4, 4'd0, 1'b1, 1'b0, 11'd8, 1'b0);
		plan_event(bhct_pkg::OP_CLOSE, 3'd0, 1);
		plan_event(3'd5, 3'd3, 1);
		plan_event(3'd6, 3'd4, 1);
		// heaviest setting: all weights 255, all limits 15, count above 8 clamps
		plan_cfg(bhct_pkg::CFG_WEIGHT_TABLE, 64'hffff_ffff_ffff_ffff);
		plan_cfg(bhct_pkg::CFG_LIMIT_TABLE, 64'h0000_0000_ffff_ffff);
		plan_cfg(bhct_pkg::CFG_BACKEND_COUNT, 64'd15);
		plan_typed(bhct_pkg::OP_QUERY, 3'd7, 16'd0, 4'd0, 1'b1, 1'b0, 11'd2040, 1'b0);
		plan_event(bhct_pkg::OP_PROBE_FAIL, 3'd3, 15);
		// failure count pinned at 15, entry already down
		plan_typed(bhct_pkg::OP_PROBE_FAIL, 3'd3, 16'd0, 4'd15, 1'b0, 1'b0, 11'd1785, 1'b0);
		plan_typed(bhct_pkg::OP_PROBE_OK, 3'd3, 16'd0, 4'd0, 1'b1, 1'b1, 11'd2040, 1'b0);
		// single entry: index 5 is out of range, weight of entry 0 still reported
		plan_cfg(bhct_pkg::CFG_BACKEND_COUNT, 64'd1);
		plan_typed(bhct_pkg::OP_QUERY, 3'd5, 16'd0, 4'd0, 1'b0, 1'b0, 11'd255, 1'b1);
		plan_event(bhct_pkg::OP_OPEN, 3'd7, 1);
		plan_event(bhct_pkg::OP_PROBE_FAIL, 3'd6, 1);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[k]) begin
			row = directed_plan[k];
			if (row.kind == ROW_CONFIG) begin
				wait_idle();
				write_register(row.reg_sel, row.value);
			end else begin
				for (rep = 0; rep < row.reps; rep++)
					send_event(row.op, row.idx, row.typed, row.want);
			end
		end

		// random part: three idling modes, each with a few register settings
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin src_stall_pct = 21; sink_stall_pct = 50; end
				1: begin src_stall_pct = 50; sink_stall_pct = 21; end
				default: begin src_stall_pct = 0; sink_stall_pct = 0; end
			endcase
			for (round = 0; round < 4; round++) begin
				// sender holds off here until every result is back
				wait_idle();

				pick = $urandom_range(99);
				if (pick < 6)
					count_val = 4'd0;
				else if (pick < 18)
					count_val = 4'($urandom_range(15, 9));
				else
					count_val = 4'($urandom_range(8, 2));

				pick = $urandom_range(99);
				if (pick < 15)
					weight_val = '0;
				else if (pick < 25)
					weight_val = '1;
				else
					weight_val = {$urandom, $urandom};

				// mostly small limits so health flips happen often
				pick = $urandom_range(99);
				if (pick < 15)
					limit_val = '0;
				else if (pick < 25)
					limit_val = '1;
				else if (pick < 70) begin
					for (k = 0; k < 8; k++)
						limit_val[4*k +: 4] = 4'($urandom_range(5));
				end else
					limit_val = $urandom;

				write_register(bhct_pkg::CFG_BACKEND_COUNT, 64'(count_val));
				write_register(bhct_pkg::CFG_WEIGHT_TABLE, weight_val);
				write_register(bhct_pkg::CFG_LIMIT_TABLE, {$urandom, limit_val});

				live = live_entries();
				for (n = 0; n < ROUND_EVENTS; n++) begin
					pick = $urandom_range(99);
					if (pick < 24)
						op = bhct_pkg::OP_OPEN;
					else if (pick < 42)
						op = bhct_pkg::OP_CLOSE;
					else if (pick < 54)
						op = bhct_pkg::OP_PROBE_OK;
					else if (pick < 84)
						op = bhct_pkg::OP_PROBE_FAIL;
					else if (pick < 94)
						op = bhct_pkg::OP_QUERY;
					else
						op = 3'($urandom_range(7, 5));
					if (live > 0 && $urandom_range(99) < 85)
						idx = 3'($urandom_range(live - 1));
					else
						idx = 3'($urandom_range(7));
					send_event(op, idx, 1'b0, '0);
				end
			end
		end

		// final drain with a bound, then a few quiet cycles for stray words
		s_axis_tvalid <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && expected_q.size() != 0; k++)
			@(negedge clk);
		repeat (HOLD_CYCLES) @(negedge clk);
		if (expected_q.size() != 0) begin
			failures++;
			$display("%0d results never arrived", expected_q.size());
		end

		$display("covered %0d events over %0d register writes: %0d index errors, %0d health flips",
			events_sent, cfg_writes, index_errors, health_flips);
		$display("checked %0d result words, %0d failures", results_checked, failures);
		if (failures == 0) begin
			$display("backend_health_connection_table regression: pass");
		end else begin
			$display("backend_health_connection_table regression: fail");
		end
		$finish;
	end

endmodule
